>>> rtl/core/hvl_pkg.sv
package hvl_pkg;

  // fixed field widths
  localparam int XY_BITS    = 16;
  localparam int RADDR_BITS = 10;
  localparam int CLIP_BITS  = 12;
  localparam int CFG_BITS   = 12;
  localparam int IDX_BITS   = 3;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] CFG_DRAW_COLOR = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_WIDTH      = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_HEIGHT     = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_STRIDE     = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_TILE_ROW   = 3'd4;

  // configuration reset values
  localparam logic        RST_DRAW_COLOR = 1'b1;
  localparam logic [11:0] RST_WIDTH      = 12'd128;
  localparam logic [6:0]  RST_HEIGHT     = 7'd8;
  localparam logic [7:0]  RST_STRIDE     = 8'd16;
  localparam logic [7:0]  RST_TILE_ROW   = 8'd0;

  typedef struct packed {
    logic        color;
    logic [11:0] width;
    logic [6:0]  height;
    logic [7:0]  stride;
    logic [7:0]  tile_row;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                  is_read;
    logic [RADDR_BITS-1:0] raddr;
    logic                  vert;
    logic [CLIP_BITS-1:0]  start;
    logic [CLIP_BITS-1:0]  fixc;
    logic [CLIP_BITS-1:0]  count;
  } cmd_t;

endpackage

>>> rtl/core/hvl_front.sv
module hvl_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           hold,
  input  hvl_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [hvl_pkg::XY_BITS-1:0]    in_start_x,
  input  logic [hvl_pkg::XY_BITS-1:0]    in_start_y,
  input  logic [hvl_pkg::XY_BITS-1:0]    in_line_length,
  input  logic [1:0]                     in_direction,
  input  logic [hvl_pkg::RADDR_BITS-1:0] in_read_address,
  input  logic                           q_ready,
  output logic                           q_push,
  output hvl_pkg::cmd_t                  q_cmd
);
  import hvl_pkg::*;

  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic                  a_valid_r;
  logic                  a_mode_r;
  logic [RADDR_BITS-1:0] a_raddr_r;
  logic                  a_vert_r;
  logic [COORD_BITS-1:0] a_lo_r;
  logic [COORD_BITS-1:0] a_fix_r;
  logic [COORD_BITS-1:0] a_len_r;

  logic [COORD_BITS-1:0] x_c, y_c, len_c, xs, ys, yr, tile_px;
  logic                  accept;

  // normalise direction and make y relative to the held tile row
  always_comb begin
    x_c     = COORD_BITS'(in_start_x);
    y_c     = COORD_BITS'(in_start_y);
    len_c   = COORD_BITS'(in_line_length);
    tile_px = COORD_BITS'({cfg.tile_row, 3'b000});
    xs      = (in_direction == 2'd2) ? x_c - len_c + ONE : x_c;
    ys      = (in_direction == 2'd3) ? y_c - len_c + ONE : y_c;
    yr      = ys - tile_px;
  end

  assign in_ready = !hold && (!a_valid_r || q_ready);
  assign accept   = in_valid && in_ready;
  assign q_push   = a_valid_r && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (q_push) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mode_r  <= in_mode;
      a_raddr_r <= in_read_address;
      a_vert_r  <= in_direction[0];
      a_lo_r    <= in_direction[0] ? yr : xs;
      a_fix_r   <= in_direction[0] ? xs : yr;
      a_len_r   <= len_c;
    end
  end

  // clip the span against the buffer
  logic [COORD_BITS-1:0] w_c, h_c, lim, olim, end_c, a, b, bc, n;
  logic                  wrapped, lo_in, empty, none;

  always_comb begin
    w_c     = COORD_BITS'(cfg.width);
    h_c     = COORD_BITS'(cfg.height);
    lim     = a_vert_r ? h_c : w_c;
    olim    = a_vert_r ? w_c : h_c;
    end_c   = a_lo_r + a_len_r;
    wrapped = a_lo_r > end_c;
    lo_in   = a_lo_r < lim;
    a       = (wrapped && !lo_in) ? '0 : a_lo_r;
    b       = (wrapped && lo_in) ? lim - ONE : end_c;
    empty   = (a >= lim) || (b == '0);
    bc      = (b > lim) ? lim : b;
    n       = bc - a;
    none    = (a_len_r == '0) || (a_fix_r >= olim) || empty;
    q_cmd.is_read = a_mode_r;
    q_cmd.raddr   = a_raddr_r;
    q_cmd.vert    = a_vert_r;
    q_cmd.start   = CLIP_BITS'(a);
    q_cmd.fixc    = CLIP_BITS'(a_fix_r);
    q_cmd.count   = (none || a_mode_r) ? '0 : CLIP_BITS'(n);
  end

endmodule

>>> rtl/core/hvl_cmd_queue.sv
module hvl_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hvl_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          head_valid,
  output hvl_pkg::cmd_t head_cmd
);
  import hvl_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign not_full   = (fill_r != 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

>>> rtl/core/hvl_back.sv
module hvl_back #(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hvl_pkg::cfg_t             cfg,
  output logic                      clearing,
  input  logic                      q_valid,
  input  hvl_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_read_data,
  output logic                      out_line_visible,
  output logic [hvl_pkg::XY_BITS-1:0] out_pixels_drawn
);
  import hvl_pkg::*;

  localparam int ADDR_BITS = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [16:0] BYTES_17 = 17'(BUFFER_BYTES);
  localparam logic [ADDR_BITS-1:0] LAST_IDX = ADDR_BITS'(BUFFER_BYTES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rdata_r;

  logic [1:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_r;
  logic                 out_valid_r;
  logic [7:0]           out_rd_r;
  logic                 out_vis_r;
  logic [XY_BITS-1:0]   out_cnt_r;

  logic                 vert_r;
  logic [CLIP_BITS-1:0] pos_r, fix_r, left_r, total_r;
  logic                 rd_ok_r;

  logic                 m_valid_r, m_ok_r;
  logic [ADDR_BITS-1:0] m_addr_r;
  logic [7:0]           m_bit_r;

  logic                 lw_valid_r;
  logic [ADDR_BITS-1:0] lw_addr_r;
  logic [7:0]           lw_data_r;

  logic                 out_free, issue, draw_done;
  logic [CLIP_BITS-1:0] px, py;
  logic [16:0]          prod, pix_addr, rd_ext;
  logic [15:0]          row_base;
  logic                 pix_ok;
  logic [7:0]           pix_bit, base_byte, new_byte;
  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_wa, mem_ra;
  logic [7:0]           mem_wd;

  assign clearing         = (state_r == ST_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rd_r;
  assign out_line_visible = out_vis_r;
  assign out_pixels_drawn = out_cnt_r;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid && out_free;
  assign issue     = (state_r == ST_DRAW) && (left_r != '0);
  assign draw_done = (state_r == ST_DRAW) && (left_r == '0) && !m_valid_r;

  // byte address of the next pixel
  always_comb begin
    px       = vert_r ? fix_r : pos_r;
    py       = vert_r ? pos_r : fix_r;
    prod     = 17'(py[CLIP_BITS-1:3]) * 17'(cfg.stride);
    row_base = {prod[12:0], 3'b000};
    pix_addr = 17'(row_base) + 17'(px);
    pix_ok   = pix_addr < BYTES_17;
    pix_bit  = 8'(1) << py[2:0];
    rd_ext   = 17'(q_cmd.raddr);
  end

  // forward the byte written last cycle, the memory read missed it
  always_comb begin
    base_byte = (lw_valid_r && (lw_addr_r == m_addr_r)) ? lw_data_r : rdata_r;
    new_byte  = cfg.color ? (base_byte | m_bit_r) : (base_byte & ~m_bit_r);
  end

  always_comb begin
    mem_we = clearing || ((state_r == ST_DRAW) && m_valid_r && m_ok_r);
    mem_wa = clearing ? clr_r : m_addr_r;
    mem_wd = clearing ? 8'h00 : new_byte;
    mem_re = issue || (q_pop && q_cmd.is_read);
    mem_ra = (state_r == ST_IDLE) ? rd_ext[ADDR_BITS-1:0] : pix_addr[ADDR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_pop) state_nxt = q_cmd.is_read ? ST_READ : ST_DRAW;
      ST_DRAW:  if (draw_done) state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      m_valid_r   <= 1'b0;
      lw_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lw_valid_r <= mem_we;
      m_valid_r  <= issue;
      if (clearing) clr_r <= clr_r + ADDR_BITS'(1);
      if (q_pop) begin
        left_r <= q_cmd.count;
      end else if (issue) begin
        left_r <= left_r - CLIP_BITS'(1);
      end
      if (draw_done || (state_r == ST_READ)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lw_addr_r <= mem_wa;
    lw_data_r <= mem_wd;
    if (q_pop) begin
      vert_r  <= q_cmd.vert;
      pos_r   <= q_cmd.start;
      fix_r   <= q_cmd.fixc;
      total_r <= q_cmd.count;
      rd_ok_r <= rd_ext < BYTES_17;
    end else if (issue) begin
      pos_r <= pos_r + CLIP_BITS'(1);
    end
    if (issue) begin
      m_addr_r <= pix_addr[ADDR_BITS-1:0];
      m_ok_r   <= pix_ok;
      m_bit_r  <= pix_bit;
    end
    if (draw_done) begin
      out_rd_r  <= 8'h00;
      out_vis_r <= (total_r != '0);
      out_cnt_r <= XY_BITS'(total_r);
    end else if (state_r == ST_READ) begin
      out_rd_r  <= rd_ok_r ? rdata_r : 8'h00;
      out_vis_r <= 1'b0;
      out_cnt_r <= '0;
    end
  end

`ifndef SYNTH
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_DRAW))
    else $error("buffer written outside clear or draw");
  a_pipe_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r |-> (state_r == ST_DRAW))
    else $error("pixel in flight outside draw");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DRAW || $past(state_r) == ST_READ))
    else $error("result raised without a finished request");
  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_line_visible == (out_pixels_drawn != '0)))
    else $error("visible flag disagrees with pixel count");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop && !out_valid_r)
    else $error("request taken during clearing sweep");
`endif

endmodule

>>> rtl/core/hv_line_page_buffer_draw_unit.sv
// Flow: requests pass the front stage and a two-entry command queue; the back end
//   then serves one request at a time and holds its result until out_ready.
// Drawing does one read-modify-write of the single byte memory per pixel, the
//   write of one pixel overlapping the read of the next.
// Reset: synchronous active-low; the buffer is then cleared by a sweep over
//   all BUFFER_BYTES bytes during which in_ready stays low; config writes still land.
module hv_line_page_buffer_draw_unit #(
  parameter int BUFFER_BYTES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hvl_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [hvl_pkg::CFG_BITS-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [hvl_pkg::XY_BITS-1:0]    in_start_x,
  input  logic [hvl_pkg::XY_BITS-1:0]    in_start_y,
  input  logic [hvl_pkg::XY_BITS-1:0]    in_line_length,
  input  logic [1:0]                     in_direction,
  input  logic [hvl_pkg::RADDR_BITS-1:0] in_read_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_read_data,
  output logic                           out_line_visible,
  output logic [hvl_pkg::XY_BITS-1:0]    out_pixels_drawn
);
  import hvl_pkg::*;

  cfg_t cfg_r;
  logic clearing;
  logic q_push, q_not_full, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color    <= RST_DRAW_COLOR;
      cfg_r.width    <= RST_WIDTH;
      cfg_r.height   <= RST_HEIGHT;
      cfg_r.stride   <= RST_STRIDE;
      cfg_r.tile_row <= RST_TILE_ROW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRAW_COLOR: cfg_r.color    <= cfg_wdata[0];
        CFG_WIDTH:      cfg_r.width    <= cfg_wdata;
        CFG_HEIGHT:     cfg_r.height   <= cfg_wdata[6:0];
        CFG_STRIDE:     cfg_r.stride   <= cfg_wdata[7:0];
        CFG_TILE_ROW:   cfg_r.tile_row <= cfg_wdata[7:0];
        default:        cfg_r          <= cfg_r;
      endcase
    end
  end

  hvl_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .hold            (clearing),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_line_length  (in_line_length),
    .in_direction    (in_direction),
    .in_read_address (in_read_address),
    .q_ready         (q_not_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  hvl_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  hvl_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .clearing         (clearing),
    .q_valid          (q_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_line_visible (out_line_visible),
    .out_pixels_drawn (out_pixels_drawn)
  );

endmodule
